@@ design/mrm_pkg.sv @@
// Shared types, codes and helpers for the memory region map.
// No dependencies.
`timescale 1ns / 1ps

package mrm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLAIM = 2'd1,
    REQ_MERGE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_USABLE = 3'd1;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] size;
    logic [2:0]  kind;
  } entry_t;

  // start + size, saturated at the top address
  function automatic logic [63:0] span_end(input logic [63:0] s, input logic [63:0] z);
    logic [64:0] sum;
    sum = {1'b0, s} + {1'b0, z};
    return sum[64] ? '1 : sum[63:0];
  endfunction

endpackage

@@ design/mrm_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mrm_rem_div.sv @@
// Bit-serial restoring remainder unit, 64-bit dividend by 32-bit divisor.
// One quotient bit per cycle. No dependencies.
`timescale 1ns / 1ps

module mrm_rem_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic [63:0] shift_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;

  assign trial = {rem_r, shift_r[63]};
  assign rem   = rem_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= 7'd64;
        shift_r <= dividend;
        rem_r   <= '0;
        dvs_r   <= divisor;
      end else if (busy_r) begin
        shift_r <= {shift_r[62:0], 1'b0};
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= 32'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[31:0];
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/memory_region_map_claim_merge_unit.sv @@
// Region table with load, claim, merge and read; uses mrm_pkg, mrm_ram, mrm_rem_div.
// Claim scans for an entry that contains the request, may run up to two remainder passes
//   and then insertion-sorts the table RAM; merge joins abutting entries of equal kind and
//   shifts the later entries down.
// Throughput: one item at a time; in_stall is high until the result beat is registered.
// Reset: synchronous, clears count, totals, load stop and handshake state; table RAM is
//   not cleared, entries at or beyond the count read as zero.
`timescale 1ns / 1ps

module memory_region_map_claim_merge_unit
  import mrm_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_region_start_in,
  input  logic [63:0] in_region_size_in,
  input  logic [2:0]  in_region_kind_in,
  input  logic [31:0] in_align_boundary,
  input  logic [4:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_success,
  output logic [63:0] out_claimed_start,
  output logic [63:0] out_claimed_size,
  output logic [2:0]  out_entry_kind,
  output logic [63:0] out_free_total,
  output logic [63:0] out_reserved_total,
  output logic [5:0]  out_region_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;
  localparam int EW = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT, ST_DONE,
    ST_CL_RD, ST_CL_CK, ST_CL_EXACT, ST_CL_DIV1, ST_CL_NZ, ST_CL_CASE, ST_CL_END,
    ST_CL_DIV2, ST_CL_SPLIT1, ST_CL_SPLIT2, ST_CL_APR, ST_CL_APC, ST_CL_TOT,
    ST_SO_I, ST_SO_KEY, ST_SO_RJ, ST_SO_CJ,
    ST_MG_A, ST_MG_AL, ST_MG_B, ST_MG_SH, ST_MG_SW, ST_MG_NX
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r, before_r, i_r, j_r;
  logic          stopped_r;
  logic [63:0]   free_r, resv_r;

  logic [63:0] cs_r, cz_r, cend_r;
  logic [2:0]  ck_r;
  logic [31:0] b_r;
  logic [63:0] rs_r, rz_r, hend_r, nz_r, ns_r, t_r, d1_r, right_r;
  logic [2:0]  hk_r;
  logic [CW-1:0] hit_r;
  entry_t      key_r;
  logic [63:0] a_s_r, a_z_r;
  logic [2:0]  a_k_r;

  logic        res_ok_r;
  logic [63:0] res_s_r, res_z_r;
  logic [2:0]  res_k_r;

  logic        out_valid_r, out_ok_r;
  logic [63:0] out_s_r, out_z_r, out_free_r, out_resv_r;
  logic [2:0]  out_k_r;
  logic [5:0]  out_cnt_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_e;

  logic        div_go, div_done;
  logic [63:0] div_a;
  logic [31:0] div_rem;

  logic        accept;
  logic [CW:0] cnt1, cnt2;
  logic        full1, full2, scan_hit, exact, sort_gt, mg_join;
  logic [63:0] e_end;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign rd_e = entry_t'(ram_rdata);
  assign e_end = span_end(rd_e.start, rd_e.size);
  assign scan_hit = (rd_e.start <= cs_r) && (cend_r <= e_end);
  assign exact = (rd_e.start == cs_r) && (rd_e.size == cz_r);
  assign cnt1 = {1'b0, count_r} + (CW+1)'(1);
  assign cnt2 = {1'b0, count_r} + (CW+1)'(2);
  assign full1 = cnt1 >= (CW+1)'(TABLE_DEPTH);
  assign full2 = cnt2 >= (CW+1)'(TABLE_DEPTH);
  assign sort_gt = (rd_e.start > key_r.start) ||
                   ((rd_e.start == key_r.start) && (rd_e.size > key_r.size));
  assign mg_join = (a_k_r == rd_e.kind) && (span_end(a_s_r, a_z_r) == rd_e.start);

  mrm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrm_rem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (b_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // table port and divider control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    div_go    = 1'b0;
    div_a     = cz_r;
    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(in_entry_index);
        if (accept && (req_t'(in_req_type) == REQ_LOAD) && !stopped_r &&
            ({1'b0, count_r} < (CW+1)'(TABLE_DEPTH)) && (in_region_kind_in != KIND_NONE)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(count_r);
          ram_wdata = '{start: in_region_start_in, size: in_region_size_in,
                        kind: in_region_kind_in};
        end
      end
      ST_CL_RD: ram_raddr = AW'(i_r);
      ST_CL_CK: begin
        if (scan_hit && !exact && !full1) begin
          div_go = 1'b1;
        end
      end
      ST_CL_EXACT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hit_r);
        ram_wdata = '{start: rs_r, size: rz_r, kind: ck_r};
      end
      ST_CL_CASE: begin
        if (rs_r == cs_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(hit_r);
          ram_wdata = '{start: rs_r + nz_r, size: rz_r - nz_r, kind: hk_r};
        end
      end
      ST_CL_END: begin
        if (span_end(cs_r, nz_r) == hend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(hit_r);
          ram_wdata = '{start: rs_r, size: rz_r - nz_r, kind: hk_r};
        end else if (!full2) begin
          div_go = 1'b1;
          div_a  = cs_r;
        end
      end
      ST_CL_SPLIT2: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hit_r);
        ram_wdata = '{start: rs_r, size: t_r, kind: hk_r};
      end
      ST_CL_APR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(count_r);
        ram_wdata = '{start: span_end(ns_r, nz_r), size: right_r, kind: KIND_USABLE};
      end
      ST_CL_APC: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(count_r);
        ram_wdata = '{start: ns_r, size: nz_r, kind: ck_r};
      end
      ST_SO_I: ram_raddr = AW'(i_r);
      ST_SO_RJ: begin
        if (j_r != '0) begin
          ram_raddr = AW'(j_r - CW'(1));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(j_r);
          ram_wdata = key_r;
        end
      end
      ST_SO_CJ: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_r);
        ram_wdata = sort_gt ? rd_e : key_r;
      end
      ST_MG_A: ram_raddr = AW'(i_r);
      ST_MG_AL: ram_raddr = AW'({1'b0, i_r} + (CW+1)'(1));
      ST_MG_B: begin
        if (mg_join) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(i_r);
          ram_wdata = '{start: a_s_r, size: a_z_r + rd_e.size, kind: a_k_r};
        end else begin
          ram_raddr = AW'({1'b0, i_r} + (CW+1)'(2));
        end
      end
      ST_MG_SH: ram_raddr = AW'({1'b0, j_r} + (CW+1)'(1));
      ST_MG_SW: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_r);
        ram_wdata = rd_e;
      end
      ST_MG_NX: ram_raddr = AW'({1'b0, i_r} + (CW+1)'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      stopped_r   <= 1'b0;
      free_r      <= '0;
      resv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cs_r     <= in_region_start_in;
            cz_r     <= in_region_size_in;
            cend_r   <= span_end(in_region_start_in, in_region_size_in);
            ck_r     <= in_region_kind_in;
            b_r      <= (in_align_boundary == '0) ? 32'd1 : in_align_boundary;
            before_r <= count_r;
            res_ok_r <= 1'b0;
            res_s_r  <= '0;
            res_z_r  <= '0;
            res_k_r  <= '0;
            i_r      <= '0;
            unique case (req_t'(in_req_type))
              REQ_LOAD: begin
                state_r <= ST_DONE;
                if (!stopped_r && ({1'b0, count_r} < (CW+1)'(TABLE_DEPTH))) begin
                  if (in_region_kind_in == KIND_NONE) begin
                    stopped_r <= 1'b1;
                  end else begin
                    count_r  <= count_r + CW'(1);
                    res_ok_r <= 1'b1;
                    res_s_r  <= in_region_start_in;
                    res_z_r  <= in_region_size_in;
                    res_k_r  <= in_region_kind_in;
                    if (in_region_kind_in == KIND_USABLE) begin
                      free_r <= free_r + in_region_size_in;
                    end else begin
                      resv_r <= resv_r + in_region_size_in;
                    end
                  end
                end
              end
              REQ_CLAIM: state_r <= ST_CL_RD;
              REQ_MERGE: begin
                res_ok_r <= 1'b1;
                state_r  <= ST_MG_A;
              end
              REQ_READ: begin
                state_r <= (XW'(in_entry_index) < XW'(count_r)) ? ST_RD_WAIT : ST_DONE;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_ok_r <= 1'b1;
          res_s_r  <= rd_e.start;
          res_z_r  <= rd_e.size;
          res_k_r  <= rd_e.kind;
          state_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_s_r     <= res_s_r;
            out_z_r     <= res_z_r;
            out_k_r     <= res_k_r;
            out_free_r  <= free_r;
            out_resv_r  <= resv_r;
            out_cnt_r   <= 6'(count_r);
            state_r     <= ST_IDLE;
          end
        end
        ST_CL_RD: begin
          state_r <= (i_r < count_r) ? ST_CL_CK : ST_DONE;
        end
        ST_CL_CK: begin
          if (scan_hit) begin
            rs_r   <= rd_e.start;
            rz_r   <= rd_e.size;
            hk_r   <= rd_e.kind;
            hend_r <= e_end;
            hit_r  <= i_r;
            if (exact) begin
              ns_r    <= cs_r;
              nz_r    <= cz_r;
              state_r <= ST_CL_EXACT;
            end else begin
              state_r <= full1 ? ST_DONE : ST_CL_DIV1;
            end
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= ST_CL_RD;
          end
        end
        ST_CL_EXACT: state_r <= ST_CL_TOT;
        ST_CL_DIV1: begin
          if (div_done) begin
            state_r <= ST_CL_NZ;
          end
        end
        ST_CL_NZ: begin
          ns_r    <= cs_r;
          nz_r    <= (div_rem == '0) ? cz_r : cz_r + 64'(b_r - div_rem);
          state_r <= ST_CL_CASE;
        end
        ST_CL_CASE: begin
          state_r <= (rs_r == cs_r) ? ST_CL_APC : ST_CL_END;
        end
        ST_CL_END: begin
          if (span_end(cs_r, nz_r) == hend_r) begin
            state_r <= ST_CL_APC;
          end else begin
            state_r <= full2 ? ST_DONE : ST_CL_DIV2;
          end
        end
        ST_CL_DIV2: begin
          if (div_done) begin
            ns_r    <= cs_r - 64'(div_rem);
            state_r <= ST_CL_SPLIT1;
          end
        end
        ST_CL_SPLIT1: begin
          t_r     <= ns_r - rs_r;
          d1_r    <= rz_r - nz_r;
          state_r <= ST_CL_SPLIT2;
        end
        ST_CL_SPLIT2: begin
          right_r <= d1_r - t_r;
          state_r <= ST_CL_APR;
        end
        ST_CL_APR: begin
          count_r <= count_r + CW'(1);
          state_r <= ST_CL_APC;
        end
        ST_CL_APC: begin
          count_r <= count_r + CW'(1);
          state_r <= ST_CL_TOT;
        end
        ST_CL_TOT: begin
          res_ok_r <= 1'b1;
          res_s_r  <= ns_r;
          res_z_r  <= nz_r;
          res_k_r  <= ck_r;
          if (ck_r == KIND_USABLE) begin
            free_r <= free_r + nz_r;
            resv_r <= resv_r - nz_r;
          end else begin
            free_r <= free_r - nz_r;
            resv_r <= resv_r + nz_r;
          end
          i_r     <= CW'(1);
          state_r <= (count_r != before_r) ? ST_SO_I : ST_DONE;
        end
        // insertion sort, stable on equal start and size
        ST_SO_I: begin
          state_r <= (i_r < count_r) ? ST_SO_KEY : ST_DONE;
        end
        ST_SO_KEY: begin
          key_r   <= rd_e;
          j_r     <= i_r;
          state_r <= ST_SO_RJ;
        end
        ST_SO_RJ: begin
          if (j_r != '0) begin
            state_r <= ST_SO_CJ;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= ST_SO_I;
          end
        end
        ST_SO_CJ: begin
          if (sort_gt) begin
            j_r     <= j_r - CW'(1);
            state_r <= ST_SO_RJ;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= ST_SO_I;
          end
        end
        ST_MG_A: begin
          state_r <= (cnt1 > (CW+1)'(count_r) && ({1'b0, i_r} + (CW+1)'(1)) <
                      {1'b0, count_r}) ? ST_MG_AL : ST_DONE;
        end
        ST_MG_AL: begin
          a_s_r   <= rd_e.start;
          a_z_r   <= rd_e.size;
          a_k_r   <= rd_e.kind;
          state_r <= ST_MG_B;
        end
        ST_MG_B: begin
          if (mg_join) begin
            a_z_r   <= a_z_r + rd_e.size;
            j_r     <= i_r + CW'(1);
            state_r <= ST_MG_SH;
          end else begin
            a_s_r <= rd_e.start;
            a_z_r <= rd_e.size;
            a_k_r <= rd_e.kind;
            i_r   <= i_r + CW'(1);
            if (({1'b0, i_r} + (CW+1)'(2)) >= {1'b0, count_r}) begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_MG_SH: begin
          if (({1'b0, j_r} + (CW+1)'(1)) < {1'b0, count_r}) begin
            state_r <= ST_MG_SW;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= ST_MG_NX;
          end
        end
        ST_MG_SW: begin
          j_r     <= j_r + CW'(1);
          state_r <= ST_MG_SH;
        end
        ST_MG_NX: begin
          state_r <= (({1'b0, i_r} + (CW+1)'(1)) < {1'b0, count_r}) ? ST_MG_B : ST_DONE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_success        = out_ok_r;
  assign out_claimed_start  = out_s_r;
  assign out_claimed_size   = out_z_r;
  assign out_entry_kind     = out_k_r;
  assign out_free_total     = out_free_r;
  assign out_reserved_total = out_resv_r;
  assign out_region_count   = out_cnt_r;

endmodule

@@ design/mrm_checker.sv @@
// Port-level checks for the region map unit, bound into the unit's module.
// Depends on memory_region_map_claim_merge_unit.
`timescale 1ns / 1ps

module mrm_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_success,
  input logic [63:0] out_claimed_start,
  input logic [63:0] out_claimed_size,
  input logic [2:0]  out_entry_kind,
  input logic [5:0]  out_region_count
);

  localparam int CAP = (TABLE_DEPTH > 63) ? 63 : TABLE_DEPTH;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_claimed_start) &&
    $stable(out_claimed_size))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_claimed_size == '0 && out_entry_kind == '0)
    else $error("failed beat carries region data");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && TABLE_DEPTH < 64 |-> out_region_count <= 6'(CAP))
    else $error("region count beyond table depth");

endmodule

bind memory_region_map_claim_merge_unit mrm_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_mrm_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_success       (out_success),
  .out_claimed_start (out_claimed_start),
  .out_claimed_size  (out_claimed_size),
  .out_entry_kind    (out_entry_kind),
  .out_region_count  (out_region_count)
);

@@ tb/region_map_checker.sv @@
// Checker for the region map unit: watches both channels, predicts each result beat
// and compares it field by field. Depends on mrm_pkg for the request and kind codes.
`timescale 1ns / 1ps

module region_map_checker
  import mrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_region_start_in,
  input  logic [63:0] in_region_size_in,
  input  logic [2:0]  in_region_kind_in,
  input  logic [31:0] in_align_boundary,
  input  logic [4:0]  in_entry_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_success,
  input  logic [63:0] out_claimed_start,
  input  logic [63:0] out_claimed_size,
  input  logic [2:0]  out_entry_kind,
  input  logic [63:0] out_free_total,
  input  logic [63:0] out_reserved_total,
  input  logic [5:0]  out_region_count,
  output int          fail_count,
  output int          outstanding
);

  localparam int DEPTH = 32;

  typedef struct {
    bit          ok;
    logic [63:0] st;
    logic [63:0] sz;
    logic [2:0]  kd;
    logic [63:0] fr;
    logic [63:0] rv;
    logic [5:0]  cnt;
  } map_result_t;

  logic [63:0] tbl_start [DEPTH];
  logic [63:0] tbl_size  [DEPTH];
  logic [2:0]  tbl_kind  [DEPTH];
  int unsigned n_valid;
  logic [63:0] free_acc;
  logic [63:0] resv_acc;
  bit          loads_closed;
  map_result_t result_q [$];
  map_result_t due;

  function automatic logic [63:0] region_limit(logic [63:0] s, logic [63:0] z);
    logic [64:0] sum;
    sum = {1'b0, s} + {1'b0, z};
    return sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
  endfunction

  function automatic void append_region(logic [63:0] s, logic [63:0] z, logic [2:0] k);
    if (n_valid < DEPTH) begin
      tbl_start[n_valid] = s;
      tbl_size[n_valid] = z;
      tbl_kind[n_valid] = k;
      n_valid++;
    end
  endfunction

  function automatic void sort_regions();
    logic [63:0] s, z;
    logic [2:0]  k;
    int          j;
    for (int i = 1; i < n_valid; i++) begin
      s = tbl_start[i];
      z = tbl_size[i];
      k = tbl_kind[i];
      j = i;
      while (j > 0 && (tbl_start[j-1] > s || (tbl_start[j-1] == s && tbl_size[j-1] > z))) begin
        tbl_start[j] = tbl_start[j-1];
        tbl_size[j] = tbl_size[j-1];
        tbl_kind[j] = tbl_kind[j-1];
        j--;
      end
      tbl_start[j] = s;
      tbl_size[j] = z;
      tbl_kind[j] = k;
    end
  endfunction

  function automatic bit try_claim(inout logic [63:0] cs, inout logic [63:0] cz,
                                   input logic [2:0] ck, input logic [63:0] b);
    int unsigned prior, hit;
    logic [63:0] cend, ns, nz, rs, rz, right;
    prior = n_valid;
    cend = region_limit(cs, cz);
    hit = DEPTH;
    for (int i = 0; i < n_valid; i++) begin
      if (tbl_start[i] <= cs && cend <= region_limit(tbl_start[i], tbl_size[i])) begin
        hit = i;
        break;
      end
    end
    if (hit == DEPTH) return 0;
    if (tbl_start[hit] == cs && tbl_size[hit] == cz) begin
      tbl_kind[hit] = ck;
    end else begin
      if (n_valid + 1 >= DEPTH) return 0;
      ns = cs;
      nz = cz;
      if (nz % b != 0) nz = (nz / b + 64'd1) * b;
      rs = tbl_start[hit];
      rz = tbl_size[hit];
      if (rs == ns) begin
        tbl_start[hit] = rs + nz;
        tbl_size[hit] = rz - nz;
      end else if (region_limit(rs, rz) == region_limit(ns, nz)) begin
        tbl_size[hit] = rz - nz;
      end else begin
        if (n_valid + 2 >= DEPTH) return 0;
        ns = (ns / b) * b;
        right = rz - nz - (ns - rs);
        tbl_size[hit] = rz - (nz + right);
        append_region(region_limit(ns, nz), right, KIND_USABLE);
      end
      append_region(ns, nz, ck);
      cs = ns;
      cz = nz;
    end
    if (ck == KIND_USABLE) begin
      free_acc += cz;
      resv_acc -= cz;
    end else begin
      free_acc -= cz;
      resv_acc += cz;
    end
    if (n_valid != prior) sort_regions();
    return 1;
  endfunction

  function automatic void merge_regions();
    int unsigned i;
    i = 0;
    while (i + 1 < n_valid) begin
      if (tbl_kind[i] == tbl_kind[i+1] &&
          region_limit(tbl_start[i], tbl_size[i]) == tbl_start[i+1]) begin
        tbl_size[i] += tbl_size[i+1];
        for (int j = i + 1; j + 1 < n_valid; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_size[j] = tbl_size[j+1];
          tbl_kind[j] = tbl_kind[j+1];
        end
        n_valid--;
      end else begin
        i++;
      end
    end
    for (int j = n_valid; j < DEPTH; j++) begin
      tbl_start[j] = '0;
      tbl_size[j] = '0;
      tbl_kind[j] = KIND_NONE;
    end
  endfunction

  function automatic map_result_t predict_beat(req_t rq, logic [63:0] s, logic [63:0] z,
                                               logic [2:0] k, logic [31:0] bnd,
                                               logic [4:0] idx);
    map_result_t r;
    logic [63:0] b, cs, cz;
    r = '{default: 0};
    b = (bnd == 0) ? 64'd1 : {32'd0, bnd};
    cs = s;
    cz = z;
    case (rq)
      REQ_LOAD: begin
        if (!loads_closed && n_valid < DEPTH) begin
          if (k == KIND_NONE) begin
            loads_closed = 1;
          end else begin
            append_region(s, z, k);
            if (k == KIND_USABLE) free_acc += z;
            else resv_acc += z;
            r.ok = 1; r.st = s; r.sz = z; r.kd = k;
          end
        end
      end
      REQ_CLAIM: begin
        if (try_claim(cs, cz, k, b)) begin
          r.ok = 1; r.st = cs; r.sz = cz; r.kd = k;
        end
      end
      REQ_MERGE: begin
        merge_regions();
        r.ok = 1;
      end
      default: begin
        r.ok = idx < n_valid;
        r.st = tbl_start[idx];
        r.sz = tbl_size[idx];
        r.kd = tbl_kind[idx];
      end
    endcase
    r.fr = free_acc;
    r.rv = resv_acc;
    r.cnt = n_valid[5:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_start[i] = '0;
        tbl_size[i] = '0;
        tbl_kind[i] = KIND_NONE;
      end
      n_valid = 0;
      free_acc = '0;
      resv_acc = '0;
      loads_closed = 0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall)
        result_q.push_back(predict_beat(req_t'(in_req_type), in_region_start_in,
                                        in_region_size_in, in_region_kind_in,
                                        in_align_boundary, in_entry_index));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected", $time);
        end else begin
          due = result_q.pop_front();
          compare_field("success", due.ok, out_success);
          compare_field("claimed_start", due.st, out_claimed_start);
          compare_field("claimed_size", due.sz, out_claimed_size);
          compare_field("entry_kind", due.kd, out_entry_kind);
          compare_field("free_total", due.fr, out_free_total);
          compare_field("reserved_total", due.rv, out_reserved_total);
          compare_field("region_count", due.cnt, out_region_count);
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the region map testbench: clock, reset, request stimulus, result-side stalls
// and the verdict. Depends on mrm_pkg, region_map_checker and the unit under test.
`timescale 1ns / 1ps

module testbench;
  import mrm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [63:0] in_region_start_in;
  logic [63:0] in_region_size_in;
  logic [2:0]  in_region_kind_in;
  logic [31:0] in_align_boundary;
  logic [4:0]  in_entry_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_success;
  logic [63:0] out_claimed_start;
  logic [63:0] out_claimed_size;
  logic [2:0]  out_entry_kind;
  logic [63:0] out_free_total;
  logic [63:0] out_reserved_total;
  logic [5:0]  out_region_count;
  int          fail_count;
  int          outstanding;
  int          idle_cycles;

  logic [63:0] known_start [$];
  logic [63:0] known_size  [$];
  logic [63:0] cursor;

  always #6 clk = ~clk;

  memory_region_map_claim_merge_unit DUT (.*);

  region_map_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[memory_region_map_claim_merge_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: mixed stall patterns, one long hold once 150 result beats have been taken
  initial begin
    int  seg, mode, rcvd;
    bit  held;
    seg = 0; mode = 0; rcvd = 0; held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) rcvd++;
      if (!held && rcvd >= 150) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 9);
        seg = (mode == 9) ? $urandom_range(5, 40) : $urandom_range(1, 25);
      end
      seg--;
      if (mode < 4) out_stall <= 1'b0;
      else if (mode < 9) out_stall <= $urandom_range(0, 1);
      else out_stall <= 1'b1;
    end
  end

  task automatic send_item(req_t rq, logic [63:0] s, logic [63:0] z, logic [2:0] k,
                           logic [31:0] b, logic [4:0] idx);
    int gap, pick;
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_region_start_in <= s;
    in_region_size_in <= z;
    in_region_kind_in <= k;
    in_align_boundary <= b;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall);
    pick = $urandom_range(0, 9);
    gap = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_boundary();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 32'd0;
    if (p < 8) return 32'd1 << $urandom_range(0, 16);
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_kind();
    return ($urandom_range(0, 9) < 6) ? KIND_USABLE : 3'($urandom_range(2, 7));
  endfunction

  task automatic load_next();
    logic [63:0] sz;
    if ($urandom_range(0, 9) == 0) cursor = {20'd0, 32'($urandom), 12'd0};
    sz = 64'($urandom_range(1, 64)) << 12;
    send_item(REQ_LOAD, cursor, sz, pick_kind(), $urandom, 5'($urandom));
    known_start.push_back(cursor);
    known_size.push_back(sz);
    if (known_start.size() > 48) begin
      void'(known_start.pop_front());
      void'(known_size.pop_front());
    end
    cursor += sz;
  endtask

  task automatic claim_known();
    int          i, mode;
    logic [63:0] rs, rz, cs, cz, off;
    logic [2:0]  k;
    i = $urandom_range(0, known_start.size() - 1);
    rs = known_start[i];
    rz = known_size[i];
    k = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : pick_kind();
    mode = $urandom_range(0, 3);
    cs = rs;
    cz = rz;
    if (mode == 1) begin
      cz = 64'($urandom_range(1, 32'(rz - 64'd1)));
    end else if (mode == 2) begin
      cz = 64'($urandom_range(1, 32'(rz - 64'd1)));
      cs = rs + rz - cz;
    end else if (mode == 3) begin
      off = 64'($urandom_range(1, 32'(rz / 64'd2)));
      cz = 64'($urandom_range(1, 32'(rz - off - 64'd1)));
      cs = rs + off;
    end
    send_item(REQ_CLAIM, cs, cz, k, pick_boundary(), 5'($urandom));
  endtask

  initial begin
    int          r;
    req_t        rq;
    logic [2:0]  k;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_LOAD;
    in_region_start_in <= '0;
    in_region_size_in <= '0;
    in_region_kind_in <= KIND_NONE;
    in_align_boundary <= '0;
    in_entry_index <= '0;
    idle_cycles <= 0;
    cursor = 64'h0000_0010_0000_0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(REQ_READ, '0, '0, KIND_NONE, 32'd1, 5'd0);
    send_item(REQ_MERGE, '0, '0, KIND_NONE, 32'd1, 5'd0);
    send_item(REQ_LOAD, 64'h10_0000, 64'h10_0000, KIND_USABLE, 32'd1, 5'd0);
    send_item(REQ_LOAD, 64'h20_0000, 64'h8000, 3'd2, 32'd1, 5'd0);
    send_item(REQ_LOAD, 64'h20_8000, 64'h8000, 3'd2, 32'd1, 5'd0);
    send_item(REQ_LOAD, 64'h30_0000, 64'h4_0000, 3'd7, 32'd1, 5'd0);
    send_item(REQ_LOAD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, KIND_USABLE, 32'd1, 5'd0);
    send_item(REQ_LOAD, '1, '1, 3'd3, '1, 5'd31);
    send_item(REQ_CLAIM, 64'h20_0000, 64'h8000, 3'd5, 32'd1, 5'd0);
    send_item(REQ_CLAIM, 64'h10_0000, 64'h1234, 3'd2, 32'h1000, 5'd0);
    send_item(REQ_CLAIM, 64'h1F_F000, 64'h1000, 3'd4, 32'd0, 5'd0);
    send_item(REQ_CLAIM, 64'h30_1003, 64'h777, 3'd6, 32'h1000, 5'd0);
    send_item(REQ_CLAIM, 64'h30_8000, 64'h100, KIND_USABLE, 32'd0, 5'd0);
    send_item(REQ_CLAIM, 64'hFFFF_FFFF_FFFF_F800, 64'h1000, 3'd2, '1, 5'd0);
    send_item(REQ_CLAIM, 64'd5, 64'd1, KIND_USABLE, 32'd1, 5'd0);
    send_item(REQ_CLAIM, 64'h20_8000, 64'h8000, 3'd2, 32'd1, 5'd0);
    send_item(REQ_CLAIM, 64'h20_0000, 64'h8000, 3'd2, 32'd1, 5'd0);
    send_item(REQ_MERGE, '1, '1, 3'd7, '1, 5'd31);
    for (int i = 0; i < 4; i++)
      send_item(REQ_READ, '0, '0, KIND_NONE, 32'd1, 5'(i));
    send_item(REQ_READ, '0, '0, KIND_NONE, 32'd1, 5'd31);
    send_item(REQ_MERGE, '0, '0, KIND_NONE, 32'd1, 5'd0);

    // random
    for (int n = 0; n < 700; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        load_next();
      end else if (r < 65 && known_start.size() > 0) begin
        claim_known();
      end else if (r < 80) begin
        send_item(REQ_MERGE, rand64(), rand64(), 3'($urandom), $urandom, 5'($urandom));
      end else if (r < 93) begin
        send_item(REQ_READ, rand64(), rand64(), 3'($urandom), $urandom, 5'($urandom));
      end else begin
        rq = req_t'($urandom_range(0, 3));
        k = 3'($urandom);
        if (rq == REQ_LOAD && k == KIND_NONE) k = KIND_USABLE;
        send_item(rq, rand64(), rand64(), k, $urandom, 5'($urandom));
      end
    end

    // load stop, then a load that must be ignored
    send_item(REQ_LOAD, rand64(), rand64(), KIND_NONE, $urandom, 5'd0);
    send_item(REQ_LOAD, cursor, 64'h1000, KIND_USABLE, 32'd1, 5'd0);
    send_item(REQ_READ, '0, '0, KIND_NONE, 32'd1, 5'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("[memory_region_map_claim_merge_unit] OK");
    else $display("[memory_region_map_claim_merge_unit] ERROR");
    $finish;
  end

endmodule
